@@ design/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescape unit
// Result status codes and the result bundle passed from decoder to output.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CntW    = $clog2(MaxRes + 1);
  localparam int unsigned IdxW    = $clog2(MaxRes);

  typedef enum logic [StatusW-1:0] {
    ST_BYTE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_BADESC  = 3'd2,
    ST_BADHEX  = 3'd3,
    ST_BADSUR  = 3'd4,
    ST_CTRL    = 3'd5
  } status_e;

  // Up to four result items from one input item; status applies to all.
  typedef struct packed {
    logic [CntW-1:0]                cnt;
    status_e                        status;
    logic [MaxRes-1:0][ByteW-1:0]   bytes;
  } res_t;

endpackage

@@ design/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode: escape decoder state and per-byte result logic
// Holds the string phase, hex accumulator and pending surrogate; computes the
// results of the registered input byte and commits the state update.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       commit_i,
  input  logic [jsu_pkg::ByteW-1:0]  byte_i,
  input  logic                       begin_i,
  output jsu_pkg::res_t              res_o
);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_STR  = 6'b000010,
    PH_ESC  = 6'b000100,
    PH_HEX  = 6'b001000,
    PH_PBS  = 6'b010000,
    PH_PU   = 6'b100000
  } phase_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChU = 8'h75;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  digits_q, digits_d;
  logic [15:0] high_q, high_d;
  logic        pair_q, pair_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;

  function automatic jsu_pkg::res_t single(input logic [7:0] b, input jsu_pkg::status_e st);
    jsu_pkg::res_t r;
    r          = '0;
    r.cnt      = jsu_pkg::CntW'(1);
    r.status   = st;
    r.bytes[0] = b;
    return r;
  endfunction

  function automatic jsu_pkg::res_t enc_utf8(input logic [20:0] cp);
    jsu_pkg::res_t r;
    r        = '0;
    r.status = jsu_pkg::ST_BYTE;
    if (cp <= 21'h7f) begin
      r.cnt      = jsu_pkg::CntW'(1);
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      r.cnt      = jsu_pkg::CntW'(2);
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.cnt      = jsu_pkg::CntW'(3);
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt      = jsu_pkg::CntW'(4);
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // Hex digit in either case.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = byte_i[3:0];
    if (byte_i inside {[8'h30:8'h39]}) begin
      hex_val = byte_i[3:0];
    end else if (byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {acc_q[11:0], hex_val};
  // 0x10000 + (high - 0xd800) * 0x400 + (low - 0xdc00)
  assign pair_cp = {5'(high_q[9:6]) + 5'd1, high_q[5:0], acc_new[9:0]};

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    digits_d = digits_q;
    high_d   = high_q;
    pair_d   = pair_q;
    res_o    = '0;
    if (begin_i) begin
      phase_d  = PH_STR;
      acc_d    = '0;
      digits_d = '0;
      high_d   = '0;
      pair_d   = 1'b0;
    end else begin
      case (phase_q)
        PH_STR: begin
          if (byte_i == ChQuote) begin
            phase_d = PH_IDLE;
            res_o   = single('0, jsu_pkg::ST_DONE);
          end else if (byte_i == ChBslash) begin
            phase_d = PH_ESC;
          end else if (byte_i < 8'h20) begin
            phase_d = PH_IDLE;
            res_o   = single('0, jsu_pkg::ST_CTRL);
          end else begin
            res_o = single(byte_i, jsu_pkg::ST_BYTE);
          end
        end
        PH_ESC: begin
          phase_d = PH_STR;
          case (byte_i)
            8'h22:   res_o = single(8'h22, jsu_pkg::ST_BYTE);
            8'h5c:   res_o = single(8'h5c, jsu_pkg::ST_BYTE);
            8'h2f:   res_o = single(8'h2f, jsu_pkg::ST_BYTE);
            8'h62:   res_o = single(8'h08, jsu_pkg::ST_BYTE);
            8'h66:   res_o = single(8'h0c, jsu_pkg::ST_BYTE);
            8'h6e:   res_o = single(8'h0a, jsu_pkg::ST_BYTE);
            8'h72:   res_o = single(8'h0d, jsu_pkg::ST_BYTE);
            8'h74:   res_o = single(8'h09, jsu_pkg::ST_BYTE);
            ChU: begin
              phase_d  = PH_HEX;
              pair_d   = 1'b0;
              acc_d    = '0;
              digits_d = '0;
            end
            default: begin
              phase_d = PH_IDLE;
              res_o   = single('0, jsu_pkg::ST_BADESC);
            end
          endcase
        end
        PH_HEX: begin
          if (!hex_ok) begin
            phase_d = PH_IDLE;
            res_o   = single('0, jsu_pkg::ST_BADHEX);
          end else begin
            acc_d = acc_new;
            if (digits_q != 2'd3) begin
              digits_d = digits_q + 2'd1;
            end else begin
              digits_d = '0;
              if (pair_q) begin
                pair_d = 1'b0;
                if (acc_new[15:10] != 6'b110111) begin
                  phase_d = PH_IDLE;
                  res_o   = single('0, jsu_pkg::ST_BADSUR);
                end else begin
                  phase_d = PH_STR;
                  res_o   = enc_utf8(pair_cp);
                end
              end else if (acc_new[15:10] == 6'b110110) begin
                high_d  = acc_new;
                phase_d = PH_PBS;
              end else begin
                phase_d = PH_STR;
                res_o   = enc_utf8({5'd0, acc_new});
              end
            end
          end
        end
        PH_PBS: begin
          if (byte_i != ChBslash) begin
            phase_d = PH_IDLE;
            res_o   = single('0, jsu_pkg::ST_BADSUR);
          end else begin
            phase_d = PH_PU;
          end
        end
        PH_PU: begin
          if (byte_i != ChU) begin
            phase_d = PH_IDLE;
            res_o   = single('0, jsu_pkg::ST_BADSUR);
          end else begin
            phase_d  = PH_HEX;
            pair_d   = 1'b1;
            acc_d    = '0;
            digits_d = '0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      digits_q <= '0;
      high_q   <= '0;
      pair_q   <= 1'b0;
    end else if (commit_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
      high_q   <= high_d;
      pair_q   <= pair_d;
    end
  end

endmodule

@@ design/jsu_obuf.sv @@
// ----------------------------------------------------------------------------
// jsu_obuf: result buffer and serializer
// Holds up to four result items of one input item and hands them out one per
// cycle while the output is ready; reports when it can take the next group.
// ----------------------------------------------------------------------------
module jsu_obuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  jsu_pkg::res_t                 res_i,
  output logic                          free_o,
  output logic                          tvalid_o,
  input  logic                          tready_i,
  output logic [jsu_pkg::ByteW-1:0]     tdata_o,
  output logic [jsu_pkg::StatusW-1:0]   tuser_o,
  output logic                          tlast_o
);

  logic [jsu_pkg::CntW-1:0]                    cnt_q, cnt_d;
  logic [jsu_pkg::IdxW-1:0]                    idx_q, idx_d;
  logic [jsu_pkg::MaxRes-1:0][jsu_pkg::ByteW-1:0] bytes_q;
  jsu_pkg::status_e                            status_q;
  logic                                        pop;
  logic                                        at_end;

  assign at_end   = (jsu_pkg::CntW'(idx_q) + jsu_pkg::CntW'(1)) == cnt_q;
  assign tvalid_o = cnt_q != '0;
  assign pop      = tvalid_o && tready_i;
  assign free_o   = !tvalid_o || (pop && at_end);
  assign tdata_o  = bytes_q[idx_q];
  assign tuser_o  = status_q;
  assign tlast_o  = at_end;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = res_i.cnt;
      idx_d = '0;
    end else if (pop) begin
      if (at_end) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + jsu_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= res_i.bytes;
      status_q <= res_i.status;
    end
  end

endmodule

@@ design/json_string_unescape_unit.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_unit: streaming JSON string unescaper with UTF-8 output
// Byte-in, byte-out decoder for the body of a JSON string.
// ----------------------------------------------------------------------------
// Feed the raw JSON text one byte per item; set tuser on the opening quote to
// start a string (that byte itself yields nothing). Plain bytes pass through,
// the two-character escapes are decoded, \uXXXX (either case, with surrogate
// pairs joined) comes out as 1 to 4 UTF-8 bytes, and a closing quote gives a
// single "done" item. Errors (bad escape, bad hex, bad surrogate pair, control
// byte) give one item with the error status and send the unit idle until the
// next opening quote. tlast marks the final result item of each input item.
// Timing: an input item is registered, then decoded and its results loaded
// into a four-entry output buffer once it can take them, so one item per
// cycle is sustained while each input yields at most one result and the
// output is ready. A \u escape that encodes to more than one UTF-8 byte
// holds the input side while the buffer drains one byte per cycle with the
// output ready. Each item passes the input register, then the output buffer.
module json_string_unescape_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] begin_req
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast    // last
);

  // input register
  logic                      in_valid_q;
  logic [jsu_pkg::ByteW-1:0] in_byte_q;
  logic                      in_begin_q;

  jsu_pkg::res_t res;
  logic          buf_free;
  logic          commit;

  // The registered byte is decoded and retired once the output buffer can
  // take its results (buffer empty, or its last item leaving this cycle).
  assign commit        = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_begin_q <= s_axis_tuser;
    end
  end

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .byte_i   (in_byte_q),
    .begin_i  (in_begin_q),
    .res_o    (res)
  );

  // Items that produce no result (escape lead-in, hex digits) load a zero
  // count, which leaves the buffer empty.
  jsu_obuf u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (commit),
    .res_i    (res),
    .free_o   (buf_free),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tuser_o  (m_axis_tuser),
    .tlast_o  (m_axis_tlast)
  );

endmodule
